FILE: design/dcg_pkg.sv
// ----------------------------------------------------------------------------
// dcg_pkg
// Shared types, widths, codes and reset values of the drive command gate.
// ----------------------------------------------------------------------------
package dcg_pkg;

  localparam int unsigned POWER_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // field widths
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned COMB_W     = SPEED_W + 1;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PPS_W      = 18;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // serial multiplier widths: both passes run PPS_W steps
  localparam int unsigned M1_W   = COMB_W + GAIN_W;
  localparam int unsigned PROD_W = M1_W + PPS_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned STEP_W = $clog2(PPS_W);

  // register reset values
  localparam logic [GAIN_W-1:0]  WHEEL_GAIN_RST    = GAIN_W'(338);
  localparam logic [PPS_W-1:0]   PWM_PER_SPEED_RST = PPS_W'(133299);
  localparam logic [OFF_W-1:0]   PWM_OFFSET_RST    = OFF_W'(10163);
  localparam logic [COUNT_W-1:0] WINDOW_TICKS_RST  = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] MIN_REPORTS_RST   = COUNT_W'(4);

  typedef enum logic [1:0] {
    ACT_VELOCITY = 2'd0,
    ACT_BUTTON   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_REPORT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_RESUME = 2'd2
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_GAIN    = 3'd0,
    REG_PWM_PER_SPEED = 3'd1,
    REG_PWM_OFFSET    = 3'd2,
    REG_WINDOW_TICKS  = 3'd3,
    REG_MIN_REPORTS   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_STOP,
    ST_PUSH
  } core_state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL1,
    LN_MUL2,
    LN_FIN
  } lane_state_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [COMB_W-1:0] mag;
  } lane_req_t;

  typedef struct packed {
    logic tick;
    logic report;
    logic stop;
    logic resume;
  } wd_event_t;

endpackage

FILE: design/dcg_lane.sv
// ----------------------------------------------------------------------------
// dcg_lane
// One wheel: bit-serial shift-add magnitude x gain, then x pwm_per_speed,
// then offset, truncation and saturation.
// ----------------------------------------------------------------------------
module dcg_lane #(
  parameter int unsigned POWER_WIDTH = dcg_pkg::POWER_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = dcg_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dcg_pkg::lane_req_t              req,
  input  logic [dcg_pkg::GAIN_W-1:0]      wheel_gain,
  input  logic [dcg_pkg::PPS_W-1:0]       pwm_per_speed,
  input  logic [dcg_pkg::OFF_W-1:0]       pwm_offset,
  output logic                            done,
  output logic signed [POWER_WIDTH-1:0]   power
);
  import dcg_pkg::*;

  localparam logic [SUM_W-1:0] LIM = (SUM_W'(1) << (POWER_WIDTH - 1)) - SUM_W'(1);

  lane_state_t state_r, state_nxt;
  logic [M1_W-1:0]   a_r;
  logic [PPS_W-1:0]  b_r;
  logic [M1_W-1:0]   hi_r;
  logic [PPS_W-1:0]  lo_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r;
  logic              nz_r;
  logic              done_r;
  logic signed [POWER_WIDTH-1:0] power_r;

  logic              last_step;
  logic              mul_active;
  logic              load_m1;
  logic [M1_W:0]     acc_sum;
  logic [PROD_W-1:0] prod_nxt;
  logic [SUM_W-1:0]  off_sh;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  mag;
  logic [POWER_WIDTH-1:0]        sat;
  logic signed [POWER_WIDTH-1:0] sat_s;
  logic signed [POWER_WIDTH-1:0] power_fin;

  assign last_step = (step_r == STEP_W'(PPS_W - 1));

  // one shift-add step: partial sum, low bit retires into lo_r
  assign acc_sum  = {1'b0, hi_r} + (b_r[0] ? {1'b0, a_r} : '0);
  assign prod_nxt = {acc_sum[M1_W:1], acc_sum[0], lo_r[PPS_W-1:1]};

  // offset only applies when magnitude x gain is nonzero; signs of both terms agree
  assign off_sh    = SUM_W'(pwm_offset) << (2 * FRAC_BITS);
  assign total     = {1'b0, hi_r, lo_r} + (nz_r ? off_sh : '0);
  assign mag       = total >> (3 * FRAC_BITS);
  assign sat       = (mag > LIM) ? LIM[POWER_WIDTH-1:0] : mag[POWER_WIDTH-1:0];
  assign sat_s     = signed'(sat);
  assign power_fin = neg_r ? -sat_s : sat_s;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LN_IDLE: if (req.start) state_nxt = LN_MUL1;
      LN_MUL1: if (last_step) state_nxt = LN_MUL2;
      LN_MUL2: if (last_step) state_nxt = LN_FIN;
      LN_FIN:  state_nxt = LN_IDLE;
    endcase
  end

  always_comb begin
    mul_active = (state_r == LN_MUL1) || (state_r == LN_MUL2);
    load_m1    = (state_r == LN_MUL1) && last_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == LN_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == LN_IDLE && req.start) begin
      a_r    <= M1_W'(wheel_gain);
      b_r    <= PPS_W'(req.mag);
      hi_r   <= '0;
      lo_r   <= '0;
      step_r <= '0;
      neg_r  <= req.neg;
    end else if (load_m1) begin
      // first product is the multiplicand of the second pass
      a_r    <= prod_nxt[M1_W-1:0];
      nz_r   <= |prod_nxt[M1_W-1:0];
      b_r    <= pwm_per_speed;
      hi_r   <= '0;
      lo_r   <= '0;
      step_r <= '0;
    end else if (mul_active) begin
      hi_r   <= prod_nxt[PROD_W-1:PPS_W];
      lo_r   <= prod_nxt[PPS_W-1:0];
      b_r    <= b_r >> 1;
      step_r <= last_step ? '0 : step_r + STEP_W'(1);
    end
    if (state_r == LN_FIN) begin
      power_r <= power_fin;
    end
  end

  assign done  = done_r;
  assign power = power_r;

endmodule

FILE: design/dcg_watchdog.sv
// ----------------------------------------------------------------------------
// dcg_watchdog
// Emergency stop latch, motor report counter and tick window that turns
// command acceptance on and off.
// ----------------------------------------------------------------------------
module dcg_watchdog (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcg_pkg::wd_event_t            ev,
  input  logic [dcg_pkg::COUNT_W-1:0]   window_ticks,
  input  logic [dcg_pkg::COUNT_W-1:0]   min_reports,
  output logic                          accepting,
  output logic                          wake
);
  import dcg_pkg::*;

  logic               stop_latched_r;
  logic               accepting_r;
  logic [COUNT_W-1:0] report_r;
  logic [COUNT_W-1:0] tick_r;

  logic [COUNT_W-1:0] win;
  logic [COUNT_W-1:0] tick_inc;
  logic               win_end;
  logic               pass;

  assign win      = (window_ticks == '0) ? COUNT_W'(1) : window_ticks;
  assign tick_inc = tick_r + COUNT_W'(1);
  assign win_end  = ev.tick && (tick_inc >= win);
  assign pass     = (report_r >= min_reports);
  // acceptance comes back: one move(0,0) item goes out
  assign wake     = win_end && !stop_latched_r && pass && !accepting_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_latched_r <= 1'b1;
      accepting_r    <= 1'b0;
      report_r       <= '0;
      tick_r         <= '0;
    end else begin
      if (ev.stop) begin
        stop_latched_r <= 1'b1;
        accepting_r    <= 1'b0;
      end else if (ev.resume) begin
        stop_latched_r <= 1'b0;
      end
      if (ev.tick) begin
        if (win_end) begin
          tick_r   <= '0;
          report_r <= '0;
          if (!stop_latched_r) accepting_r <= pass;
        end else begin
          tick_r <= tick_inc;
        end
      end
      if (ev.report && report_r != '1) begin
        report_r <= report_r + COUNT_W'(1);
      end
    end
  end

  assign accepting = accepting_r;

endmodule

FILE: design/drive_command_gate_core.sv
// ----------------------------------------------------------------------------
// drive_command_gate_core
// Velocity path: when a velocity item changes the wheel powers, its move item
//   follows two 18-step shift-add passes in each wheel lane (both lanes in
//   parallel) and the pending and output registers; else no item goes out.
// Throughput: non-velocity items are taken every cycle, but in_ready stays
//   low while a velocity item is worked on or a produced item is handed on.
// Reset: stopped, not accepting, counters and last powers zero; no sweep.
// ----------------------------------------------------------------------------
module drive_command_gate_core #(
  parameter int unsigned POWER_WIDTH = dcg_pkg::POWER_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = dcg_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dcg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dcg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_action,
  input  logic signed [dcg_pkg::SPEED_W-1:0] in_linear_speed,
  input  logic signed [dcg_pkg::SPEED_W-1:0] in_turn_rate,
  input  logic                               in_stop_button,
  input  logic                               in_resume_button,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_command,
  output logic signed [POWER_WIDTH-1:0]      out_power_a,
  output logic signed [POWER_WIDTH-1:0]      out_power_b,
  output logic                               out_last
);
  import dcg_pkg::*;

  logic [GAIN_W-1:0]  wheel_gain_r;
  logic [PPS_W-1:0]   pwm_per_speed_r;
  logic [OFF_W-1:0]   pwm_offset_r;
  logic [COUNT_W-1:0] window_ticks_r;
  logic [COUNT_W-1:0] min_reports_r;

  core_state_t state_r, state_nxt;
  logic signed [POWER_WIDTH-1:0] prior_left_r, prior_right_r;
  command_t                      pend_cmd_r;
  logic signed [POWER_WIDTH-1:0] pend_a_r, pend_b_r;

  logic                          out_valid_r;
  command_t                      out_command_r;
  logic signed [POWER_WIDTH-1:0] out_power_a_r, out_power_b_r;
  logic                          out_last_r;

  action_t               act;
  logic                  accept;
  logic                  slot_free;
  logic                  out_load;
  logic                  lane_start;
  logic                  accepting;
  logic                  wake;
  wd_event_t             wd_ev;
  logic signed [COMB_W-1:0] comb_l, comb_r;
  lane_req_t             req_l, req_r;
  logic                  lane_done_l, lane_done_r;
  logic signed [POWER_WIDTH-1:0] pow_l, pow_r;
  logic                  changed;

  assign act       = action_t'(in_action);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign changed   = (pow_l != prior_left_r) || (pow_r != prior_right_r);

  assign comb_l = {in_linear_speed[SPEED_W-1], in_linear_speed}
                - {in_turn_rate[SPEED_W-1], in_turn_rate};
  assign comb_r = {in_linear_speed[SPEED_W-1], in_linear_speed}
                + {in_turn_rate[SPEED_W-1], in_turn_rate};

  always_comb begin
    req_l.start = lane_start;
    req_l.neg   = comb_l[COMB_W-1];
    req_l.mag   = comb_l[COMB_W-1] ? COMB_W'(-comb_l) : COMB_W'(comb_l);
    req_r.start = lane_start;
    req_r.neg   = comb_r[COMB_W-1];
    req_r.mag   = comb_r[COMB_W-1] ? COMB_W'(-comb_r) : COMB_W'(comb_r);
  end

  always_comb begin
    wd_ev.tick   = accept && (act == ACT_TICK);
    wd_ev.report = accept && (act == ACT_REPORT);
    wd_ev.stop   = accept && (act == ACT_BUTTON) && in_stop_button;
    wd_ev.resume = accept && (act == ACT_BUTTON) && !in_stop_button && in_resume_button;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_VELOCITY: if (accepting) state_nxt = ST_CALC;
            ACT_BUTTON: begin
              if (in_stop_button) state_nxt = ST_STOP;
              else if (in_resume_button) state_nxt = ST_PUSH;
            end
            ACT_TICK:   if (wake) state_nxt = ST_PUSH;
            ACT_REPORT: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CALC: if (lane_done_l) state_nxt = changed ? ST_PUSH : ST_IDLE;
      ST_STOP: if (slot_free) state_nxt = ST_PUSH;
      ST_PUSH: if (slot_free) state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    lane_start = accept && (act == ACT_VELOCITY) && accepting;
    out_load   = slot_free && ((state_r == ST_STOP) || (state_r == ST_PUSH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      wheel_gain_r    <= WHEEL_GAIN_RST;
      pwm_per_speed_r <= PWM_PER_SPEED_RST;
      pwm_offset_r    <= PWM_OFFSET_RST;
      window_ticks_r  <= WINDOW_TICKS_RST;
      min_reports_r   <= MIN_REPORTS_RST;
      prior_left_r    <= '0;
      prior_right_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WHEEL_GAIN:    wheel_gain_r    <= cfg_wdata[GAIN_W-1:0];
          REG_PWM_PER_SPEED: pwm_per_speed_r <= cfg_wdata[PPS_W-1:0];
          REG_PWM_OFFSET:    pwm_offset_r    <= cfg_wdata[OFF_W-1:0];
          REG_WINDOW_TICKS:  window_ticks_r  <= cfg_wdata[COUNT_W-1:0];
          REG_MIN_REPORTS:   min_reports_r   <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (wd_ev.stop) begin
        prior_left_r  <= '0;
        prior_right_r <= '0;
      end else if (state_r == ST_CALC && lane_done_l && changed) begin
        prior_left_r  <= pow_l;
        prior_right_r <= pow_r;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // pending item and output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd_r <= wd_ev.resume ? CMD_RESUME : CMD_MOVE;
      pend_a_r   <= '0;
      pend_b_r   <= '0;
    end else if (state_r == ST_CALC && lane_done_l) begin
      pend_cmd_r <= CMD_MOVE;
      pend_a_r   <= -pow_r;
      pend_b_r   <= pow_l;
    end
    if (out_load) begin
      if (state_r == ST_STOP) begin
        out_command_r <= CMD_STOP;
        out_power_a_r <= '0;
        out_power_b_r <= '0;
        out_last_r    <= 1'b0;
      end else begin
        out_command_r <= pend_cmd_r;
        out_power_a_r <= pend_a_r;
        out_power_b_r <= pend_b_r;
        out_last_r    <= 1'b1;
      end
    end
  end

  dcg_lane #(
    .POWER_WIDTH (POWER_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lane_left (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req_l),
    .wheel_gain    (wheel_gain_r),
    .pwm_per_speed (pwm_per_speed_r),
    .pwm_offset    (pwm_offset_r),
    .done          (lane_done_l),
    .power         (pow_l)
  );

  dcg_lane #(
    .POWER_WIDTH (POWER_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lane_right (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req_r),
    .wheel_gain    (wheel_gain_r),
    .pwm_per_speed (pwm_per_speed_r),
    .pwm_offset    (pwm_offset_r),
    .done          (lane_done_r),
    .power         (pow_r)
  );

  dcg_watchdog u_watchdog (
    .clk          (clk),
    .rst_n        (rst_n),
    .ev           (wd_ev),
    .window_ticks (window_ticks_r),
    .min_reports  (min_reports_r),
    .accepting    (accepting),
    .wake         (wake)
  );

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_power_a = out_power_a_r;
  assign out_power_b = out_power_b_r;
  assign out_last    = out_last_r;

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done_l |-> (state_r == ST_CALC))
    else $error("wheel lane finished outside of calc");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done_l == lane_done_r)
    else $error("wheel lanes out of step");

  a_stop_drops_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (act == ACT_BUTTON) && in_stop_button)
      |=> (!accepting && (state_r == ST_STOP)))
    else $error("stop did not drop acceptance");

  a_stop_then_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (state_r == ST_STOP))
      |=> ((state_r == ST_PUSH) && (pend_cmd_r == CMD_MOVE) && !out_last_r))
    else $error("stop item not followed by move");

endmodule
